### rtl/ss_pkg.sv
// ----------------------------------------------------------------------------
// ss_pkg
// Shared types and codes for the sorted set engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ss_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 64;

  localparam logic [2:0] CMD_INSERT   = 3'd0;
  localparam logic [2:0] CMD_DELETE   = 3'd1;
  localparam logic [2:0] CMD_SEARCH   = 3'd2;
  localparam logic [2:0] CMD_RETRIEVE = 3'd3;
  localparam logic [2:0] CMD_CLEAR    = 3'd4;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_DUP    = 3'd1;
  localparam logic [2:0] ST_ABSENT = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_RANK   = 3'd4;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] read_value;
    logic [6:0]         element_count;
    logic               is_empty;
  } ss_res_t;

endpackage

`default_nettype wire

### rtl/ss_ifs.sv
// ----------------------------------------------------------------------------
// ss_ifs
// Valid/ready channel interfaces for commands and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ss_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [31:0] value;
  logic [5:0]         rank;

  modport source (output valid, output cmd, output value, output rank, input ready);
  modport sink   (input valid, input cmd, input value, input rank, output ready);
endinterface

interface ss_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] read_value;
  logic [6:0]         element_count;
  logic               is_empty;

  modport source (output valid, output status, output read_value,
                  output element_count, output is_empty, input ready);
  modport sink   (input valid, input status, input read_value,
                  input element_count, input is_empty, output ready);
endinterface

`default_nettype wire

### rtl/ss_cmp.sv
// ----------------------------------------------------------------------------
// ss_cmp
// Shared signed 32-bit compare unit used by every search probe.
// ----------------------------------------------------------------------------
`default_nettype none

module ss_cmp (
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic                    lt,
  output logic                    eq
);

  assign lt = (a < b);
  assign eq = (a == b);

endmodule

`default_nettype wire

### rtl/ss_seq.sv
// ----------------------------------------------------------------------------
// ss_seq
// Sequencer and value store: binary search through the shared compare unit,
// then one-entry-per-step shifting for insert and delete.
// ----------------------------------------------------------------------------
`default_nettype none

module ss_seq import ss_pkg::*; #(
  parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [2:0]         cmd,
  input  wire logic signed [31:0] value,
  input  wire logic [5:0]         rank,
  input  wire logic               slot_free,
  output logic                    ready,
  output logic                    res_valid,
  output ss_res_t                 res
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > 6) ? CW : 6;

  typedef enum logic [3:0] {
    S_IDLE, S_PROBE, S_CMP, S_DECIDE, S_SH_RD, S_SH_WR, S_INS, S_RANK_WAIT, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [2:0]         cmd_r, cmd_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [5:0]         rank_r, rank_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      lo_r, lo_nxt;
  logic [CW-1:0]      hi_r, hi_nxt;
  logic [CW-1:0]      mid_r, mid_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               hit_r, hit_nxt;
  logic [2:0]         status_r, status_nxt;
  logic signed [31:0] rdval_r, rdval_nxt;

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rd_data_r;
  logic [AW-1:0]      rd_addr;
  logic               we;
  logic [AW-1:0]      wa;
  logic signed [31:0] wd;

  logic               cmp_lt, cmp_eq;
  logic [CW:0]        sum;
  logic [CW-1:0]      mid;
  logic [CW-1:0]      idx_m1, idx_p1;
  logic [XW-1:0]      rank_x, cnt_x;
  logic [CW+6:0]      cnt_ext;

  ss_cmp u_cmp (
    .a  (rd_data_r),
    .b  (val_r),
    .lt (cmp_lt),
    .eq (cmp_eq)
  );

  assign sum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid    = sum[CW:1];
  assign idx_m1 = idx_r - CW'(1);
  assign idx_p1 = idx_r + CW'(1);
  assign rank_x = XW'(rank_r);
  assign cnt_x  = XW'(cnt_r);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    val_nxt    = val_r;
    rank_nxt   = rank_r;
    cnt_nxt    = cnt_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    idx_nxt    = idx_r;
    hit_nxt    = hit_r;
    status_nxt = status_r;
    rdval_nxt  = rdval_r;
    rd_addr    = '0;
    we         = 1'b0;
    wa         = '0;
    wd         = val_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = cmd;
          val_nxt    = value;
          rank_nxt   = rank;
          lo_nxt     = '0;
          hi_nxt     = cnt_r;
          hit_nxt    = 1'b0;
          status_nxt = ST_OK;
          rdval_nxt  = '0;
          state_nxt  = S_PROBE;
        end
      end
      S_PROBE: begin
        if (lo_r < hi_r) begin
          rd_addr   = mid[AW-1:0];
          mid_nxt   = mid;
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_CMP: begin
        if (cmp_lt) begin
          lo_nxt = mid_r + CW'(1);
        end else begin
          hi_nxt = mid_r;
        end
        if (cmp_eq) begin
          hit_nxt = 1'b1;
        end
        state_nxt = S_PROBE;
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        unique case (cmd_r)
          CMD_INSERT: begin
            if (hit_r) begin
              status_nxt = ST_DUP;
            end else if (cnt_r >= CW'(CAPACITY)) begin
              status_nxt = ST_FULL;
            end else begin
              idx_nxt   = cnt_r;
              state_nxt = S_SH_RD;
            end
          end
          CMD_DELETE: begin
            if (!hit_r) begin
              status_nxt = ST_ABSENT;
            end else begin
              idx_nxt   = lo_r;
              state_nxt = S_SH_RD;
            end
          end
          CMD_SEARCH: begin
            status_nxt = hit_r ? ST_OK : ST_ABSENT;
          end
          CMD_RETRIEVE: begin
            if (rank_x < cnt_x) begin
              rd_addr   = rank_x[AW-1:0];
              state_nxt = S_RANK_WAIT;
            end else begin
              status_nxt = ST_RANK;
            end
          end
          CMD_CLEAR: begin
            cnt_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_SH_RD: begin
        if (cmd_r == CMD_INSERT) begin
          if (idx_r > lo_r) begin
            rd_addr   = idx_m1[AW-1:0];
            state_nxt = S_SH_WR;
          end else begin
            state_nxt = S_INS;
          end
        end else begin
          if (idx_p1 < cnt_r) begin
            rd_addr   = idx_p1[AW-1:0];
            state_nxt = S_SH_WR;
          end else begin
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = S_DONE;
          end
        end
      end
      S_SH_WR: begin
        we        = 1'b1;
        wa        = idx_r[AW-1:0];
        wd        = rd_data_r;
        idx_nxt   = (cmd_r == CMD_INSERT) ? idx_m1 : idx_p1;
        state_nxt = S_SH_RD;
      end
      S_INS: begin
        we        = 1'b1;
        wa        = lo_r[AW-1:0];
        wd        = val_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_DONE;
      end
      S_RANK_WAIT: begin
        rdval_nxt = rd_data_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    cmd_r    <= cmd_nxt;
    val_r    <= val_nxt;
    rank_r   <= rank_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    idx_r    <= idx_nxt;
    hit_r    <= hit_nxt;
    status_r <= status_nxt;
    rdval_r  <= rdval_nxt;
  end

  assign cnt_ext = {7'd0, cnt_r};

  assign ready     = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    res.status        = status_r;
    res.read_value    = rdval_r;
    res.element_count = cnt_ext[6:0];
    res.is_empty      = (cnt_r == '0);
  end

endmodule

`default_nettype wire

### rtl/sorted_set_engine.sv
// ----------------------------------------------------------------------------
// sorted_set_engine
// Bounded store of distinct signed 32-bit values kept in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one command per transaction (insert, delete, search,
//   retrieve by rank, clear) with its value and rank. out_chan returns
//   exactly one transaction per command: status, read value, element count
//   and empty flag after the operation.
//   Each command runs a binary search over the store: one read of the value
//   memory and one pass through the shared compare unit per probe, up to
//   clog2(count+1) probes. Insert then moves the entries above the insertion
//   point up one at a time, delete moves the entries above the removed one
//   down, each moved entry taking a read state and a write state; insert
//   finally writes the new value, delete lowers the count, and retrieve adds
//   a read of the ranked entry. One command is in flight at a time;
//   in_chan.ready is high only while the sequencer is idle. A result waits
//   in the output register while out_chan.ready is low; the next command is
//   taken meanwhile and holds at completion until the register frees. Reset
//   empties the store with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_set_engine import ss_pkg::*; #(
  parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ss_in_if.sink     in_chan,
  ss_out_if.source  out_chan
);

  logic    seq_ready;
  logic    res_valid;
  ss_res_t res;
  logic    slot_free;
  logic    in_fire;

  logic    out_valid_r, out_valid_nxt;
  ss_res_t out_res_r, out_res_nxt;

  assign in_fire   = in_chan.valid && seq_ready;
  assign slot_free = !out_valid_r || out_chan.ready;

  ss_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_fire),
    .cmd       (in_chan.cmd),
    .value     (in_chan.value),
    .rank      (in_chan.rank),
    .slot_free (slot_free),
    .ready     (seq_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && slot_free) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign in_chan.ready          = seq_ready;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_res_r.status;
  assign out_chan.read_value    = out_res_r.read_value;
  assign out_chan.element_count = out_res_r.element_count;
  assign out_chan.is_empty      = out_res_r.is_empty;

`ifndef SYNTHESIS
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !res_valid)
    else $error("result one cycle after command transaction");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !seq_ready)
    else $error("input ready while a result is pending");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (CAPACITY < 128)) |-> (res.is_empty == (res.element_count == 7'd0)))
    else $error("empty flag disagrees with element count");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && slot_free) |=> (out_valid_r && !res_valid))
    else $error("completed result not handed to output register");
`endif

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_set_engine. A scoreboard keeps its own
// ascending copy of the set and predicts status, read value, count and the
// empty flag for every accepted command. Directed corner cases come first,
// then insert-heavy, mixed and delete-heavy random phases with random idling
// on both channels, one long output hold-off and one drain pause.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import ss_pkg::*; ();

  localparam int unsigned CAPACITY = DEFAULT_CAPACITY;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SEG_ITEMS = 75;
  localparam int NUM_SEGS = 11;
  localparam int POOL_SIZE = 96;

  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} op_mix_t;

  class set_tracker_t;
    int unsigned capacity;
    logic signed [31:0] members[$];
    ss_res_t expected_results[$];
    int errors;
    int checked;
    int peak;
    int status_hits[8];

    function new(int unsigned cap);
      capacity = cap;
      errors = 0;
      checked = 0;
      peak = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void note_command(logic [2:0] cmd, logic signed [31:0] value,
                               logic [5:0] rank);
      int pos;
      bit hit;
      ss_res_t r;
      pos = 0;
      while (pos < members.size() && members[pos] < value) pos++;
      hit = (pos < members.size()) && (members[pos] == value);
      r = '0;
      r.status = ST_OK;
      case (cmd)
        CMD_INSERT: begin
          if (hit) r.status = ST_DUP;
          else if (members.size() >= capacity) r.status = ST_FULL;
          else members.insert(pos, value);
        end
        CMD_DELETE: begin
          if (!hit) r.status = ST_ABSENT;
          else members.delete(pos);
        end
        CMD_SEARCH: r.status = hit ? ST_OK : ST_ABSENT;
        CMD_RETRIEVE: begin
          if (rank < members.size()) r.read_value = members[rank];
          else r.status = ST_RANK;
        end
        CMD_CLEAR: members.delete();
        default: ;
      endcase
      r.element_count = 7'(members.size());
      r.is_empty = (members.size() == 0);
      if (members.size() > peak) peak = members.size();
      expected_results.push_back(r);
    endfunction

    function void cmp_field(string name, longint e, longint a);
      if (e != a) begin
        errors++;
        $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, e, a);
      end
    endfunction

    function void check_result(ss_res_t got);
      ss_res_t e;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result: expected none, actual status %0d count %0d",
                 $time, got.status, got.element_count);
        return;
      end
      e = expected_results.pop_front();
      checked++;
      status_hits[e.status]++;
      cmp_field("status", e.status, got.status);
      cmp_field("read_value", e.read_value, got.read_value);
      cmp_field("element_count", e.element_count, got.element_count);
      cmp_field("is_empty", e.is_empty, got.is_empty);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit burst_mode;
  bit long_hold_req;
  int idle_cycles;
  int sent;
  logic signed [31:0] value_pool[POOL_SIZE];
  set_tracker_t sb;

  ss_in_if in_if();
  ss_out_if out_if();

  sorted_set_engine #(.CAPACITY(CAPACITY)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] pick_value(int hit_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < hit_pct && sb.members.size() > 0)
      return sb.members[$urandom_range(0, sb.members.size() - 1)];
    if (r < hit_pct + 45) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_cmd(op_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 70) return CMD_INSERT;
        if (r < 78) return CMD_DELETE;
        if (r < 88) return CMD_SEARCH;
        if (r < 98) return CMD_RETRIEVE;
      end
      MIX_BALANCED: begin
        if (r < 30) return CMD_INSERT;
        if (r < 55) return CMD_DELETE;
        if (r < 72) return CMD_SEARCH;
        if (r < 92) return CMD_RETRIEVE;
        if (r < 94) return CMD_CLEAR;
      end
      default: begin
        if (r < 10) return CMD_INSERT;
        if (r < 65) return CMD_DELETE;
        if (r < 78) return CMD_SEARCH;
        if (r < 95) return CMD_RETRIEVE;
        if (r < 96) return CMD_CLEAR;
      end
    endcase
    return 3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
  endfunction

  task automatic send_cmd(logic [2:0] cmd, logic signed [31:0] value, logic [5:0] rank);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.cmd   <= cmd;
    in_if.value <= value;
    in_if.rank  <= rank;
    do @(posedge clk); while (!in_if.ready);
    sb.note_command(cmd, value, rank);
    sent++;
  endtask

  task automatic run_phase(op_mix_t mix, int count);
    logic [2:0] cmd;
    logic [5:0] rank;
    int hit_pct;
    hit_pct = (mix == MIX_FILL) ? 15 : (mix == MIX_DRAIN) ? 45 : 30;
    repeat (count) begin
      cmd = pick_cmd(mix);
      if (sb.members.size() > 0 && $urandom_range(0, 99) < 70)
        rank = 6'($urandom_range(0, sb.members.size() - 1));
      else
        rank = 6'($urandom_range(0, 63));
      send_cmd(cmd, pick_value(hit_pct), rank);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
  endtask

  // result receiver: random stalls, one long hold-off on request
  initial begin
    int stall_left;
    int r;
    bit hold_done;
    stall_left = 0;
    hold_done = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        out_if.ready <= 1'b1;
      end else if (burst_mode) begin
        out_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 30) begin
        r = $urandom_range(0, 99);
        stall_left = (r < 80) ? $urandom_range(0, 2) :
                     (r < 97) ? $urandom_range(3, 14) : $urandom_range(19, 79);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    ss_res_t got;
    if (out_if.valid && out_if.ready) begin
      got.status = out_if.status;
      got.read_value = out_if.read_value;
      got.element_count = out_if.element_count;
      got.is_empty = out_if.is_empty;
      sb.check_result(got);
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("** sorted_set_engine: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    op_mix_t plan[NUM_SEGS];
    plan = '{MIX_FILL, MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_FILL, MIX_FILL,
             MIX_BALANCED, MIX_DRAIN, MIX_FILL, MIX_FILL, MIX_BALANCED};
    sb = new(CAPACITY);
    sent = 0;
    burst_mode = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_INSERT;
    in_if.value = '0;
    in_if.rank = '0;
    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    value_pool[2] = 32'sd0;
    value_pool[3] = -32'sd1;
    value_pool[4] = 32'sd1;
    for (int i = 5; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // corner cases on an empty, small and cleared store
    send_cmd(CMD_SEARCH, 32'sd0, 6'd0);
    send_cmd(CMD_DELETE, 32'sd5, 6'd0);
    send_cmd(CMD_RETRIEVE, 32'sd0, 6'd0);
    send_cmd(CMD_CLEAR, 32'sd0, 6'd0);
    send_cmd(CMD_INSERT, 32'sd0, 6'd0);
    send_cmd(CMD_INSERT, VAL_MIN, 6'd0);
    send_cmd(CMD_INSERT, VAL_MAX, 6'd0);
    send_cmd(CMD_INSERT, -32'sd1, 6'd0);
    send_cmd(CMD_INSERT, 32'sd1, 6'd0);
    send_cmd(CMD_INSERT, 32'sd0, 6'd0);
    send_cmd(CMD_SEARCH, VAL_MIN, 6'd0);
    send_cmd(CMD_SEARCH, 32'sd2, 6'd0);
    send_cmd(CMD_RETRIEVE, 32'sd0, 6'd0);
    send_cmd(CMD_RETRIEVE, 32'sd0, 6'd4);
    send_cmd(CMD_RETRIEVE, 32'sd0, 6'd5);
    send_cmd(CMD_RETRIEVE, VAL_MAX, 6'd63);
    send_cmd(CMD_DELETE, -32'sd1, 6'd0);
    send_cmd(CMD_DELETE, -32'sd1, 6'd0);
    send_cmd(CMD_SPARE_A, -32'sd1, 6'd63);
    send_cmd(CMD_SPARE_B, VAL_MIN, 6'd21);
    send_cmd(CMD_SPARE_C, VAL_MAX, 6'd42);
    send_cmd(CMD_DELETE, VAL_MAX, 6'd0);
    send_cmd(CMD_CLEAR, 32'sd0, 6'd0);
    send_cmd(CMD_RETRIEVE, 32'sd0, 6'd0);

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      if (seg == 2) long_hold_req = 1'b1;
      if (seg == 4) wait_drained();
      burst_mode = (seg == 5);
      run_phase(plan[seg], SEG_ITEMS);
    end
    burst_mode = 1'b0;
    @(negedge clk);
    in_if.valid <= 1'b0;

    wait_drained();
    repeat (200) @(posedge clk);

    $display("Ran %0d commands, checked %0d results; peak occupancy %0d of %0d.",
             sent, sb.checked, sb.peak, CAPACITY);
    $display("Refusals seen: %0d duplicate, %0d absent, %0d full, %0d rank out of range.",
             sb.status_hits[ST_DUP], sb.status_hits[ST_ABSENT],
             sb.status_hits[ST_FULL], sb.status_hits[ST_RANK]);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("** sorted_set_engine: PASSED **");
    end else begin
      $display("** sorted_set_engine: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
